[hdl/twbh_pkg.sv]
// Package for the two-way bucket hash map: payload types, result codes, register
// indexes, the hash prime and the coefficient LFSR step.
// Has no dependencies; the top level and the hash unit import it.
`default_nettype none

package twbh_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BUCKETS_DEF      = 1024;
  localparam int SLOTS_PER_BUCKET_DEF = 2;
  localparam int HANDLE_BITS_DEF      = 32;

  // A map holding more than this many entries per bucket grows instead of reseeding.
  localparam int CROWD_FACTOR = 2;

  // 2^35 - 2^31 - 1
  localparam logic [34:0] HASH_PRIME = 35'h7_7FFF_FFFF;
  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;

  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_INIT_MULT = 2'd0;
  localparam logic [1:0] REG_INIT_ADD  = 2'd1;
  localparam logic [1:0] REG_SEED      = 2'd2;

  localparam logic CMD_GET    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_RM_MISSING = 3'd3,
    ST_FULL       = 3'd4,
    ST_ZERO_KEY   = 3'd5
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [63:0] key;
    logic [31:0] handle;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [11:0] entry_count;
  } out_t;

  // One step of the Galois LFSR; a zero state is first replaced by one.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] v;
    v = (s == 32'd0) ? 32'd1 : s;
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction

endpackage

`default_nettype wire

[hdl/two_way_bucket_hash_map.sv]
// Top level of the two-way bucket hash map: configuration registers, sequencer,
// two slot banks that swap roles after a rebuild, and the shared hash unit.
// Depends on twbh_pkg, twbh_bank and twbh_hash.
//
//   channel   ports                                    direction
//   input     in_valid, in_stall, in_data (in_t)       item in, stall out
//   result    out_valid, out_stall, out_data (out_t)   result out, stall in
//   config    psel, penable, pwrite, paddr, pwdata,    APB write and read
//             prdata, pready
//
// After reset the active bank is cleared one slot a cycle, all MAX_BUCKETS *
// SLOTS_PER_BUCKET slots, with in_stall high. A plain get or remove runs the
// shared hash unit (two multiplier passes and then its folding steps) and then
// reads and checks each slot of the bucket in turn. A rebuild clears the
// shadow bank (one slot a cycle) and then walks every slot of the current size,
// hashing each occupied one again. One item is worked at a time; the next one
// is taken while the previous result still waits behind out_stall.
`default_nettype none

module two_way_bucket_hash_map #(
  parameter int MAX_BUCKETS      = twbh_pkg::MAX_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = twbh_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int HANDLE_BITS      = twbh_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire twbh_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output twbh_pkg::out_t                   out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [twbh_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import twbh_pkg::*;

  localparam int NSLOT = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int SW    = AW + 1;
  localparam int OW    = $clog2(NSLOT + 1);
  localparam int KW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int LG_W  = $clog2(BKT_W + 2);
  localparam int CW    = AW + 3;
  localparam int HW    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK_START, S_LOOK_WAIT, S_SCAN_RD, S_SCAN_CHK, S_ROOM,
    S_RB_CLR, S_RB_RD, S_RB_LAT, S_RB_HW, S_RB_SRD, S_RB_SCHK, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic            bank_sel_r, bank_sel_nxt;
  logic [LG_W-1:0] size_log_r, size_log_nxt, lg_r, lg_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [31:0]     mult_r, mult_nxt, add_r, add_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  logic [1:0]      retry_r, retry_nxt;
  logic [31:0]     lfsr_r, lfsr_nxt;
  logic [31:0]     imult_r, iadd_r, iseed_r;
  logic            cmd_r, cmd_nxt;
  logic [63:0]     key_r, key_nxt, rk_r, rk_nxt;
  logic [HW-1:0]   hdl_r, hdl_nxt, rh_r, rh_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   base_r, base_nxt, emp_addr_r, emp_addr_nxt;
  logic            emp_found_r, emp_found_nxt, room_r, room_nxt;
  logic [SW-1:0]   s_r, s_nxt;
  status_t         res_status_r, res_status_nxt;
  logic [31:0]     res_hout_r, res_hout_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  // Bank ports seen as active (src) and shadow (dst).
  logic          src_we, dst_we;
  logic [AW-1:0] src_waddr, dst_waddr, src_raddr, dst_raddr;
  logic [63:0]   src_wkey, dst_wkey, src_rkey, dst_rkey;
  logic [HW-1:0] src_whdl, dst_whdl, src_rhdl, dst_rhdl;

  logic          b0_we, b1_we;
  logic [AW-1:0] b0_waddr, b1_waddr, b0_raddr, b1_raddr;
  logic [63:0]   b0_wkey, b1_wkey, b0_rkey, b1_rkey;
  logic [HW-1:0] b0_whdl, b1_whdl, b0_rhdl, b1_rhdl;

  logic             hash_start, hash_done;
  logic [31:0]      hash_mult, hash_add;
  logic [63:0]      hash_key;
  logic [LG_W-1:0]  hash_lg;
  logic [BKT_W-1:0] hash_bkt;

  logic          cfg_wr;
  logic [SW-1:0] cur_full, cur_slots;
  logic [AW-1:0] slot_addr;
  logic          k_last, grow, too_big;
  logic [31:0]   draw_a, draw_b;

  twbh_bank #(.DEPTH(NSLOT), .AW(AW), .HW(HW)) u_bank0 (
    .clk(clk), .wr_en(b0_we), .wr_addr(b0_waddr), .wr_key(b0_wkey),
    .wr_handle(b0_whdl), .rd_addr(b0_raddr), .rd_key(b0_rkey), .rd_handle(b0_rhdl)
  );

  twbh_bank #(.DEPTH(NSLOT), .AW(AW), .HW(HW)) u_bank1 (
    .clk(clk), .wr_en(b1_we), .wr_addr(b1_waddr), .wr_key(b1_wkey),
    .wr_handle(b1_whdl), .rd_addr(b1_raddr), .rd_key(b1_rkey), .rd_handle(b1_rhdl)
  );

  twbh_hash #(.BKT_W(BKT_W), .LG_W(LG_W)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .mult(hash_mult), .add(hash_add),
    .key(hash_key), .lg(hash_lg), .done(hash_done), .bucket(hash_bkt)
  );

  always_comb begin
    if (!bank_sel_r) begin
      b0_we = src_we;  b0_waddr = src_waddr; b0_wkey = src_wkey; b0_whdl = src_whdl;
      b0_raddr = src_raddr;
      b1_we = dst_we;  b1_waddr = dst_waddr; b1_wkey = dst_wkey; b1_whdl = dst_whdl;
      b1_raddr = dst_raddr;
      src_rkey = b0_rkey; src_rhdl = b0_rhdl; dst_rkey = b1_rkey; dst_rhdl = b1_rhdl;
    end else begin
      b1_we = src_we;  b1_waddr = src_waddr; b1_wkey = src_wkey; b1_whdl = src_whdl;
      b1_raddr = src_raddr;
      b0_we = dst_we;  b0_waddr = dst_waddr; b0_wkey = dst_wkey; b0_whdl = dst_whdl;
      b0_raddr = dst_raddr;
      src_rkey = b1_rkey; src_rhdl = b1_rhdl; dst_rkey = b0_rkey; dst_rhdl = b0_rhdl;
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_INIT_MULT: prdata = imult_r;
      REG_INIT_ADD:  prdata = iadd_r;
      REG_SEED:      prdata = iseed_r;
      default:       prdata = 32'd0;
    endcase
  end

  assign cur_full  = SW'(SLOTS_PER_BUCKET) << size_log_r;
  assign cur_slots = (cur_full > SW'(NSLOT)) ? SW'(NSLOT) : cur_full;
  assign slot_addr = base_r + AW'(k_r);
  assign k_last    = (k_r == KW'(SLOTS_PER_BUCKET - 1));
  assign grow      = (CW'(occ_r) > (CW'(CROWD_FACTOR) << lg_r)) || (retry_r == 2'd2);
  assign too_big   = (CW'(2) << lg_r) > CW'(MAX_BUCKETS);
  assign draw_a    = lfsr_step(lfsr_r);
  assign draw_b    = lfsr_step(draw_a);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    bank_sel_nxt   = bank_sel_r;
    size_log_nxt   = size_log_r;
    lg_nxt         = lg_r;
    occ_nxt        = occ_r;
    mult_nxt       = mult_r;
    add_nxt        = add_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    retry_nxt      = retry_r;
    lfsr_nxt       = lfsr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    hdl_nxt        = hdl_r;
    rk_nxt         = rk_r;
    rh_nxt         = rh_r;
    k_nxt          = k_r;
    base_nxt       = base_r;
    emp_addr_nxt   = emp_addr_r;
    emp_found_nxt  = emp_found_r;
    room_nxt       = room_r;
    s_nxt          = s_r;
    res_status_nxt = res_status_r;
    res_hout_nxt   = res_hout_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_data_nxt   = out_data_r;

    src_we = 1'b0; src_waddr = slot_addr; src_wkey = 64'd0; src_whdl = '0;
    src_raddr = slot_addr;
    dst_we = 1'b0; dst_waddr = slot_addr; dst_wkey = 64'd0; dst_whdl = '0;
    dst_raddr = slot_addr;

    hash_start = 1'b0;
    hash_mult  = mult_r;
    hash_add   = add_r;
    hash_key   = key_r;
    hash_lg    = size_log_r;

    unique case (state_r)
      S_CLEAR: begin
        src_we    = 1'b1;
        src_waddr = s_r[AW-1:0];
        if (s_r == SW'(NSLOT - 1)) begin
          s_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          s_nxt = s_r + SW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.cmd;
          key_nxt = in_data.key;
          hdl_nxt = in_data.handle[HW-1:0];
          if (occ_r == '0) begin
            mult_nxt = imult_r;
            add_nxt  = iadd_r;
          end
          room_nxt = 1'b0;
          if (in_data.key == 64'd0) begin
            res_status_nxt = ST_ZERO_KEY;
            res_hout_nxt   = 32'd0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_LOOK_START;
          end
        end
      end

      S_LOOK_START: begin
        hash_start = 1'b1;
        state_nxt  = S_LOOK_WAIT;
      end

      S_LOOK_WAIT: begin
        if (hash_done) begin
          base_nxt      = AW'(hash_bkt) * AW'(SLOTS_PER_BUCKET);
          k_nxt         = '0;
          emp_found_nxt = 1'b0;
          state_nxt     = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (cmd_r == CMD_GET) begin
          if (src_rkey == key_r) begin
            res_status_nxt = ST_FOUND;
            res_hout_nxt   = 32'(src_rhdl);
            state_nxt      = S_DONE;
          end else begin
            if (src_rkey == 64'd0 && !emp_found_r) begin
              emp_found_nxt = 1'b1;
              emp_addr_nxt  = slot_addr;
            end
            if (!k_last) begin
              k_nxt     = k_r + KW'(1);
              state_nxt = S_SCAN_RD;
            end else if (emp_found_r || src_rkey == 64'd0) begin
              src_we         = 1'b1;
              src_waddr      = emp_found_r ? emp_addr_r : slot_addr;
              src_wkey       = key_r;
              src_whdl       = hdl_r;
              occ_nxt        = occ_r + OW'(1);
              res_status_nxt = ST_INSERTED;
              res_hout_nxt   = 32'(hdl_r);
              state_nxt      = S_DONE;
            end else begin
              // Bucket full: start or continue making room.
              if (!room_r) begin
                room_nxt  = 1'b1;
                retry_nxt = 2'd0;
                ca_nxt    = mult_r;
                cb_nxt    = add_r;
              end
              lg_nxt    = size_log_r;
              state_nxt = S_ROOM;
            end
          end
        end else begin
          if (src_rkey != 64'd0 && src_rhdl == hdl_r) begin
            src_we         = 1'b1;
            if (occ_r != '0) begin
              occ_nxt = occ_r - OW'(1);
            end
            res_status_nxt = ST_REMOVED;
            res_hout_nxt   = 32'd0;
            state_nxt      = S_DONE;
          end else if (!k_last) begin
            k_nxt     = k_r + KW'(1);
            state_nxt = S_SCAN_RD;
          end else begin
            res_status_nxt = ST_RM_MISSING;
            res_hout_nxt   = 32'd0;
            state_nxt      = S_DONE;
          end
        end
      end

      S_ROOM: begin
        if (grow) begin
          if (too_big) begin
            res_status_nxt = ST_FULL;
            res_hout_nxt   = 32'd0;
            state_nxt      = S_DONE;
          end else begin
            lg_nxt    = lg_r + LG_W'(1);
            retry_nxt = 2'd0;
            s_nxt     = '0;
            state_nxt = S_RB_CLR;
          end
        end else begin
          ca_nxt    = draw_a;
          cb_nxt    = draw_b;
          lfsr_nxt  = draw_b;
          retry_nxt = retry_r + 2'd1;
          s_nxt     = '0;
          state_nxt = S_RB_CLR;
        end
      end

      S_RB_CLR: begin
        dst_we    = 1'b1;
        dst_waddr = s_r[AW-1:0];
        if (s_r == SW'(NSLOT - 1)) begin
          s_nxt     = '0;
          state_nxt = S_RB_RD;
        end else begin
          s_nxt = s_r + SW'(1);
        end
      end

      S_RB_RD: begin
        src_raddr = s_r[AW-1:0];
        if (s_r == cur_slots) begin
          // Every entry placed: the shadow bank becomes the active one.
          bank_sel_nxt = ~bank_sel_r;
          size_log_nxt = lg_r;
          mult_nxt     = ca_r;
          add_nxt      = cb_r;
          state_nxt    = S_LOOK_START;
        end else begin
          state_nxt = S_RB_LAT;
        end
      end

      S_RB_LAT: begin
        hash_mult = ca_r;
        hash_add  = cb_r;
        hash_key  = src_rkey;
        hash_lg   = lg_r;
        if (src_rkey == 64'd0) begin
          s_nxt     = s_r + SW'(1);
          state_nxt = S_RB_RD;
        end else begin
          hash_start = 1'b1;
          rk_nxt     = src_rkey;
          rh_nxt     = src_rhdl;
          state_nxt  = S_RB_HW;
        end
      end

      S_RB_HW: begin
        if (hash_done) begin
          base_nxt  = AW'(hash_bkt) * AW'(SLOTS_PER_BUCKET);
          k_nxt     = '0;
          state_nxt = S_RB_SRD;
        end
      end

      S_RB_SRD: begin
        state_nxt = S_RB_SCHK;
      end

      S_RB_SCHK: begin
        if (dst_rkey == 64'd0) begin
          dst_we    = 1'b1;
          dst_wkey  = rk_r;
          dst_whdl  = rh_r;
          s_nxt     = s_r + SW'(1);
          state_nxt = S_RB_RD;
        end else if (k_last) begin
          state_nxt = S_ROOM;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_RB_SRD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.handle_out  = res_hout_r;
          out_data_nxt.entry_count = 12'(occ_r);
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr && paddr[3:2] == REG_SEED) begin
      lfsr_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bank_sel_r  <= 1'b0;
      size_log_r  <= LG_W'(1);
      occ_r       <= '0;
      mult_r      <= 32'd1;
      add_r       <= 32'd0;
      retry_r     <= 2'd0;
      lfsr_r      <= 32'd1;
      imult_r     <= 32'd1;
      iadd_r      <= 32'd0;
      iseed_r     <= 32'd1;
      room_r      <= 1'b0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_sel_r  <= bank_sel_nxt;
      size_log_r  <= size_log_nxt;
      occ_r       <= occ_nxt;
      mult_r      <= mult_nxt;
      add_r       <= add_nxt;
      retry_r     <= retry_nxt;
      lfsr_r      <= lfsr_nxt;
      room_r      <= room_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_INIT_MULT: imult_r <= pwdata;
          REG_INIT_ADD:  iadd_r  <= pwdata;
          REG_SEED:      iseed_r <= pwdata;
          default: ;
        endcase
      end
    end
    lg_r         <= lg_nxt;
    ca_r         <= ca_nxt;
    cb_r         <= cb_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    hdl_r        <= hdl_nxt;
    rk_r         <= rk_nxt;
    rh_r         <= rh_nxt;
    k_r          <= k_nxt;
    base_r       <= base_nxt;
    emp_addr_r   <= emp_addr_nxt;
    emp_found_r  <= emp_found_nxt;
    res_status_r <= res_status_nxt;
    res_hout_r   <= res_hout_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

[hdl/twbh_bank.sv]
// One slot bank of the hash map: key and handle arrays, one write port and one
// registered read port. Depends on nothing but its parameters.
`default_nettype none

module twbh_bank #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int HW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [63:0]   wr_key,
  input  wire logic [HW-1:0] wr_handle,
  input  wire logic [AW-1:0] rd_addr,
  output logic [63:0]        rd_key,
  output logic [HW-1:0]      rd_handle
);

  logic [63:0]   mem_key [DEPTH];
  logic [HW-1:0] mem_hdl [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_hdl[wr_addr] <= wr_handle;
    end
    rd_key    <= mem_key[rd_addr];
    rd_handle <= mem_hdl[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/twbh_hash.sv]
// Shared hash unit: one 32x32 multiplier used twice, then a shift-add folding loop
// that reduces modulo the hash prime. Depends on twbh_pkg.
`default_nettype none

module twbh_hash #(
  parameter int BKT_W = 10,
  parameter int LG_W  = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      mult,
  input  wire logic [31:0]      add,
  input  wire logic [63:0]      key,
  input  wire logic [LG_W-1:0]  lg,
  output logic                  done,
  output logic [BKT_W-1:0]      bucket
);

  import twbh_pkg::*;

  typedef enum logic [2:0] {H_IDLE, H_MLO, H_MHI, H_ADD, H_RED} hstate_t;

  hstate_t         st_r;
  logic [31:0]     a_r, b_r;
  logic [63:0]     key_r, acc_r, prod_r;
  logic [LG_W-1:0] lg_r;
  logic            done_r;
  logic [BKT_W-1:0] bucket_r;

  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [28:0] hi;
  logic [34:0] rem;

  assign mul_b = (st_r == H_MHI) ? key_r[63:32] : key_r[31:0];
  assign mul_p = a_r * mul_b;
  assign hi    = acc_r[63:35];
  // The folded value is below 2^35, which is under twice the prime.
  assign rem   = (acc_r[34:0] >= HASH_PRIME) ? (acc_r[34:0] - HASH_PRIME) : acc_r[34:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        H_IDLE: begin
          if (start) begin
            a_r   <= mult;
            b_r   <= add;
            key_r <= key;
            lg_r  <= lg;
            st_r  <= H_MLO;
          end
        end
        H_MLO: begin
          acc_r <= mul_p;
          st_r  <= H_MHI;
        end
        H_MHI: begin
          prod_r <= mul_p;
          st_r   <= H_ADD;
        end
        H_ADD: begin
          acc_r <= acc_r + {prod_r[31:0], 32'h0} + {32'h0, b_r};
          st_r  <= H_RED;
        end
        H_RED: begin
          // 2^35 is congruent to 2^31 + 1, so the high part folds back in.
          if (hi != 29'd0) begin
            acc_r <= (64'(hi) << 31) + 64'(hi) + 64'(acc_r[34:0]);
          end else begin
            bucket_r <= rem[BKT_W-1:0] & ~({BKT_W{1'b1}} << lg_r);
            done_r   <= 1'b1;
            st_r     <= H_IDLE;
          end
        end
        default: st_r <= H_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

`default_nettype wire
